>>> rtl/core/sph_pkg.sv
// ---------------------------------------------------------------------------
// sph_pkg: shared types and constants for the sphere point generator
// Word format handed along the cell chain, CORDIC and square root constants.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sph_pkg;

  // number of square root digit steps (one result bit each)
  localparam int SQRT_STEPS = 16;

  // largest number of CORDIC micro-rotations with a table entry
  localparam int ATAN_ENTRIES = 24;

  // inverse CORDIC gain in Q30
  localparam logic signed [31:0] INV_GAIN_Q30 = 32'sd652032874;

  // 1.0 in Q1.30
  localparam logic [30:0] ONE_Q30 = 31'h4000_0000;

  // eighth turn offset for rounding to the nearest quadrant
  localparam logic [32:0] EIGHTH_TURN = 33'h0_2000_0000;

  // vector length after reset, sqrt(3)/2 in Q0.15
  localparam logic [14:0] LEN_RESET = 15'd28378;

  // Q15 saturation bound of the square root
  localparam logic [14:0] Q15_MAX = 15'h7FFF;

  // arctangent of 2^-i in units of 2^-32 turn
  localparam logic signed [31:0] ATAN_TURNS [ATAN_ENTRIES] = '{
    32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
    32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
    32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
    32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
    32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
    32'sd652,       32'sd326,       32'sd163,       32'sd81
  };

  // word handed from cell to cell
  typedef struct packed {
    logic [1:0]         quad;     // quadrant folded off the phase
    logic signed [31:0] cx;       // CORDIC x, Q30
    logic signed [31:0] cy;       // CORDIC y, Q30
    logic signed [31:0] ang;      // residual angle, 2^-32 turn
    logic [30:0]        rem;      // square root remainder
    logic [31:0]        root;     // square root partial result
    logic signed [15:0] cos_p;    // polar cosine, Q1.15
  } sph_word_t;

endpackage

>>> rtl/core/sphere_point_from_uniforms.sv
// Stages: CORDIC_STAGES or 16 cells, whichever is more, plus an input stage
// and two scaling stages.
// Throughput: one word per cycle while the output is not stalled, set by the one-step-per-cell chain.
// Reset: synchronous active-low rst_n empties every stage and loads the
// vector length with sqrt(3)/2.
// ---------------------------------------------------------------------------
// sphere_point_from_uniforms: random point on a sphere from two draws
// Azimuth via a CORDIC chain, polar sine via a digit-serial square root in the
// same cells, then scaled by the vector length register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_point_from_uniforms
  import sph_pkg::*;
#(
  parameter int ANGLE_BITS    = 16,
  parameter int CORDIC_STAGES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // input word: turn_fraction[15:0], polar_cosine[31:16]
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,
  // result word: comp_x[15:0], comp_y[31:16], comp_z[47:32]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,
  // vector length register write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [14:0] cfg_data
);

  localparam int N_CELLS = (CORDIC_STAGES > SQRT_STEPS) ? CORDIC_STAGES : SQRT_STEPS;

  logic [14:0]        len_r;
  logic               valid_c [N_CELLS + 1];
  logic               ready_c [N_CELLS + 1];
  sph_word_t          word_c  [N_CELLS + 1];
  logic signed [15:0] comp_x;
  logic signed [15:0] comp_y;
  logic signed [15:0] comp_z;

  // vector length register
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r <= LEN_RESET;
    end else if (cfg_valid) begin
      len_r <= cfg_data;
    end
  end

  sph_front #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (s_axis_tvalid),
    .in_ready     (s_axis_tready),
    .turn_fraction(s_axis_tdata[15:0]),
    .polar_cosine (s_axis_tdata[31:16]),
    .out_valid    (valid_c[0]),
    .out_ready    (ready_c[0]),
    .out_word     (word_c[0])
  );

  // chain of cells
  generate
    for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      sph_cell #(
        .IDX          (i),
        .CORDIC_STAGES(CORDIC_STAGES)
      ) u_cell (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (valid_c[i]),
        .in_ready (ready_c[i]),
        .in_word  (word_c[i]),
        .out_valid(valid_c[i + 1]),
        .out_ready(ready_c[i + 1]),
        .out_word (word_c[i + 1])
      );
    end
  endgenerate

  sph_scale u_scale (
    .clk      (clk),
    .rst_n    (rst_n),
    .len      (len_r),
    .in_valid (valid_c[N_CELLS]),
    .in_ready (ready_c[N_CELLS]),
    .in_word  (word_c[N_CELLS]),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .comp_x   (comp_x),
    .comp_y   (comp_y),
    .comp_z   (comp_z)
  );

  assign m_axis_tdata = {comp_z, comp_y, comp_x};

endmodule

>>> rtl/core/sph_front.sv
// ---------------------------------------------------------------------------
// sph_front: input conditioning stage
// Cuts the azimuth to the angle width, folds it to the nearest quadrant and
// forms 1 - c^2 in Q1.30 as the square root radicand.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_front
  import sph_pkg::*;
#(
  parameter int ANGLE_BITS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [15:0]       turn_fraction,
  input  logic signed [15:0] polar_cosine,
  output logic              out_valid,
  input  logic              out_ready,
  output sph_word_t         out_word
);

  localparam int DROP = (ANGLE_BITS < 16) ? 16 - ANGLE_BITS : 0;
  localparam logic [15:0] KEEP_MASK = 16'hFFFF << DROP;

  logic              valid_r;
  sph_word_t         word_r;
  sph_word_t         word_nxt;
  logic [31:0]       phase;
  logic [32:0]       phase_rnd;
  logic [1:0]        quad;
  logic [31:0]       rest;
  logic [31:0]       csq;

  // quadrant fold and radicand
  always_comb begin
    phase     = {turn_fraction & KEEP_MASK, 16'h0000};
    phase_rnd = {1'b0, phase} + EIGHTH_TURN;
    quad      = phase_rnd[31:30];
    rest      = phase - {quad, 30'h0000_0000};
    csq       = 32'(polar_cosine * polar_cosine);

    word_nxt       = '0;
    word_nxt.quad  = quad;
    word_nxt.cx    = INV_GAIN_Q30;
    word_nxt.cy    = '0;
    word_nxt.ang   = $signed(rest);
    word_nxt.rem   = ONE_Q30 - csq[30:0];
    word_nxt.root  = '0;
    word_nxt.cos_p = polar_cosine;
  end

  assign in_ready = ~valid_r | out_ready;

  // stage register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

>>> rtl/core/sph_cell.sv
// ---------------------------------------------------------------------------
// sph_cell: one cell of the processing chain
// Does one CORDIC micro-rotation and one square root digit step, each only
// where its index is within that algorithm's step count.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_cell
  import sph_pkg::*;
#(
  parameter int IDX           = 0,
  parameter int CORDIC_STAGES = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  sph_word_t in_word,
  output logic      out_valid,
  input  logic      out_ready,
  output sph_word_t out_word
);

  localparam int SQ_SH = (IDX < SQRT_STEPS) ? 30 - 2 * IDX : 0;
  localparam logic [32:0] SQ_BIT = 33'd1 << SQ_SH;

  logic      valid_r;
  sph_word_t word_r;
  sph_word_t word_nxt;
  sph_word_t rot_word;

  // CORDIC micro-rotation
  generate
    if (IDX < CORDIC_STAGES) begin : g_rot
      always_comb begin
        rot_word = in_word;
        if (!in_word.ang[31]) begin
          rot_word.cx  = in_word.cx - (in_word.cy >>> IDX);
          rot_word.cy  = in_word.cy + (in_word.cx >>> IDX);
          rot_word.ang = in_word.ang - ATAN_TURNS[IDX];
        end else begin
          rot_word.cx  = in_word.cx + (in_word.cy >>> IDX);
          rot_word.cy  = in_word.cy - (in_word.cx >>> IDX);
          rot_word.ang = in_word.ang + ATAN_TURNS[IDX];
        end
      end
    end else begin : g_no_rot
      assign rot_word = in_word;
    end
  endgenerate

  // square root digit step
  generate
    if (IDX < SQRT_STEPS) begin : g_sqrt
      logic [32:0] trial;
      always_comb begin
        trial    = {1'b0, in_word.root} + SQ_BIT;
        word_nxt = rot_word;
        if ({2'b00, in_word.rem} >= trial) begin
          word_nxt.rem  = 31'({2'b00, in_word.rem} - trial);
          word_nxt.root = 32'({2'b00, in_word.root[31:1]} + SQ_BIT);
        end else begin
          word_nxt.root = {1'b0, in_word.root[31:1]};
        end
      end
    end else begin : g_no_sqrt
      assign word_nxt = rot_word;
    end
  endgenerate

  assign in_ready = ~valid_r | out_ready;

  // cell register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      word_r <= word_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_word  = word_r;

endmodule

>>> rtl/core/sph_scale.sv
// ---------------------------------------------------------------------------
// sph_scale: output scaling stages
// First stage: saturated sine times length, z, quadrant unfold. Second stage:
// amplitude times cosine and sine of the azimuth, rounded and saturated.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sph_scale
  import sph_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic [14:0]       len,
  input  logic              in_valid,
  output logic              in_ready,
  input  sph_word_t         in_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic signed [15:0] comp_x,
  output logic signed [15:0] comp_y,
  output logic signed [15:0] comp_z
);

  // round a Q45 product to Q15 and clamp to 16 bits
  function automatic logic signed [15:0] round_sat(input logic signed [47:0] p);
    logic signed [47:0] r;
    r = (p + 48'sh0000_2000_0000) >>> 30;
    if (r > 48'sd32767) begin
      return 16'sh7FFF;
    end else if (r < -48'sd32768) begin
      return -16'sh8000;
    end
    return r[15:0];
  endfunction

  logic              a_valid_r;
  logic [14:0]       amp_r;
  logic signed [31:0] co_r;
  logic signed [31:0] si_r;
  logic signed [15:0] z_r;

  logic              b_valid_r;
  logic signed [15:0] x_r;
  logic signed [15:0] y_r;
  logic signed [15:0] zo_r;

  logic              a_ready;
  logic              b_ready;
  logic [14:0]       sin_q15;
  logic [29:0]       amp_prod;
  logic [30:0]       amp_rnd;
  logic signed [31:0] z_prod;
  logic signed [31:0] z_rnd;
  logic signed [31:0] co_nxt;
  logic signed [31:0] si_nxt;
  logic signed [47:0] px;
  logic signed [47:0] py;

  // stage A: amplitude, z and quadrant unfold
  always_comb begin
    sin_q15  = (in_word.root > {17'h0, Q15_MAX}) ? Q15_MAX : in_word.root[14:0];
    amp_prod = len * sin_q15;
    amp_rnd  = {1'b0, amp_prod} + 31'h0000_4000;
    z_prod   = $signed({1'b0, len}) * in_word.cos_p;
    z_rnd    = (z_prod + 32'sh0000_4000) >>> 15;
    unique case (in_word.quad)
      2'd0: begin
        co_nxt = in_word.cx;
        si_nxt = in_word.cy;
      end
      2'd1: begin
        co_nxt = -in_word.cy;
        si_nxt = in_word.cx;
      end
      2'd2: begin
        co_nxt = -in_word.cx;
        si_nxt = -in_word.cy;
      end
      default: begin
        co_nxt = in_word.cy;
        si_nxt = -in_word.cx;
      end
    endcase
  end

  // stage B products
  always_comb begin
    px = $signed({1'b0, amp_r}) * co_r;
    py = $signed({1'b0, amp_r}) * si_r;
  end

  assign b_ready  = ~b_valid_r | out_ready;
  assign a_ready  = ~a_valid_r | b_ready;
  assign in_ready = a_ready;

  // stage valids
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) begin
        a_valid_r <= in_valid;
      end
      if (b_ready) begin
        b_valid_r <= a_valid_r;
      end
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      amp_r <= amp_rnd[29:15];
      co_r  <= co_nxt;
      si_r  <= si_nxt;
      z_r   <= z_rnd[15:0];
    end
    if (b_ready && a_valid_r) begin
      x_r  <= round_sat(px);
      y_r  <= round_sat(py);
      zo_r <= z_r;
    end
  end

  assign out_valid = b_valid_r;
  assign comp_x    = x_r;
  assign comp_y    = y_r;
  assign comp_z    = zo_r;

endmodule

>>> sim/sphere_point_from_uniforms_test.sv
// ---------------------------------------------------------------------------
// sphere_point_from_uniforms_test: self-checking bench for the sphere point block
// Streams azimuth and polar cosine draws through the block under random
// backpressure and several vector lengths. A scoreboard predicts every result
// word in fixed point and checks it field by field, in order.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sphere_point_from_uniforms_test;
  import sph_pkg::*;

  localparam int PIPE_LATENCY   = 19;
  localparam int SETTLE_CYCLES  = 2 * PIPE_LATENCY;
  localparam int HOLD_CYCLES    = 120;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int ROTATIONS      = 16;

  // CORDIC start value in Q30 and arctangent steps in units of 2^-32 turn
  localparam longint INV_GAIN = 64'sd652032874;
  localparam longint ARCTAN_TURNS [ROTATIONS] = '{
    536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
    10679838, 5340245, 2670163, 1335087, 667544, 333772,
    166886, 83443, 41722, 20861
  };

  typedef struct packed {
    logic signed [15:0] z;
    logic signed [15:0] y;
    logic signed [15:0] x;
  } point_t;

  // expected sphere points, in order of acceptance
  class point_scoreboard;
    point_t queued[$];
    longint length;
    int     errors;

    function new();
      length = longint'(LEN_RESET);
      errors = 0;
    endfunction

    function void set_length(logic [14:0] value);
      length = longint'(value);
    endfunction

    function int pending();
      return queued.size();
    endfunction

    function logic signed [15:0] clip16(longint v);
      if (v > 32767) return 16'sh7FFF;
      if (v < -32768) return 16'sh8000;
      return v[15:0];
    endfunction

    function point_t predict(logic [15:0] turn, logic signed [15:0] pcos);
      logic [32:0] biased;
      logic [1:0]  quad;
      logic [31:0] residue;
      longint      ang, cx, cy, nx, co, si, c, radicand, root, trial, sin_q, amp;
      int          i;
      point_t      p;
      // fold the azimuth to the nearest quadrant
      biased  = {1'b0, turn, 16'h0000} + 33'h0_2000_0000;
      quad    = biased[31:30];
      residue = {turn, 16'h0000} - {quad, 30'd0};
      ang     = longint'($signed(residue));
      // rotation mode CORDIC in Q30
      cx = INV_GAIN;
      cy = 0;
      for (i = 0; i < ROTATIONS; i++) begin
        if (ang >= 0) begin
          nx  = cx - (cy >>> i);
          cy  = cy + (cx >>> i);
          ang = ang - ARCTAN_TURNS[i];
        end else begin
          nx  = cx + (cy >>> i);
          cy  = cy - (cx >>> i);
          ang = ang + ARCTAN_TURNS[i];
        end
        cx = nx;
      end
      case (quad)
        2'd0: begin co = cx;  si = cy;  end
        2'd1: begin co = -cy; si = cx;  end
        2'd2: begin co = -cx; si = -cy; end
        default: begin co = cy; si = -cx; end
      endcase
      // polar sine: floor square root of 1 - c^2, capped below 1.0
      c        = longint'(pcos);
      radicand = (64'sd1 <<< 30) - c * c;
      root     = 0;
      for (i = 15; i >= 0; i--) begin
        trial = root + (64'sd1 <<< i);
        if (trial * trial <= radicand) root = trial;
      end
      sin_q = (root > 32767) ? 32767 : root;
      // scale by the vector length, round half up
      amp = (length * sin_q + 16384) >>> 15;
      p.x = clip16((amp * co + (64'sd1 <<< 29)) >>> 30);
      p.y = clip16((amp * si + (64'sd1 <<< 29)) >>> 30);
      p.z = clip16((length * c + 16384) >>> 15);
      return p;
    endfunction

    function void note_input(logic [15:0] turn, logic signed [15:0] pcos);
      queued.push_back(predict(turn, pcos));
    endfunction

    function void field_check(string name, logic signed [15:0] exp_v,
                              logic signed [15:0] act_v);
      if (exp_v !== act_v) begin
        errors++;
        $display("%0t: %s mismatch, expected %0d, actual %0d",
                 $time, name, exp_v, act_v);
      end
    endfunction

    function void check_result(logic [47:0] word);
      point_t exp_p;
      if (queued.size() == 0) begin
        errors++;
        $display("%0t: unexpected result word, expected none, actual %h",
                 $time, word);
        return;
      end
      exp_p = queued.pop_front();
      field_check("comp_x", exp_p.x, word[15:0]);
      field_check("comp_y", exp_p.y, word[31:16]);
      field_check("comp_z", exp_p.z, word[47:32]);
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata;   // turn_fraction[15:0], polar_cosine[31:16]
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [47:0] m_axis_tdata;   // comp_x[15:0], comp_y[31:16], comp_z[47:32]
  logic        cfg_valid;
  logic        cfg_ready;
  logic [14:0] cfg_data;

  point_scoreboard sb;
  bit calm     = 1'b0;
  bit hold_req = 1'b0;
  int quiet_cycles = 0;

  sphere_point_from_uniforms uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // monitor and watchdog: handshakes sampled at the edge
  always @(posedge clk) begin
    if (rst_n && s_axis_tvalid && s_axis_tready)
      sb.note_input(s_axis_tdata[15:0], s_axis_tdata[31:16]);
    if (rst_n && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 5) - 1) @(posedge clk);
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // offer one word, return at the edge where it is taken
  task automatic send_item(input logic [15:0] turn, input logic [15:0] pcos);
    if (!calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {pcos, turn};
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // stop sending and wait for every outstanding point
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  // length write, only with the pipeline empty
  task automatic program_length(input logic [14:0] value);
    wait_drained();
    repeat (PIPE_LATENCY) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_length(value);
  endtask

  // quadrant edges, the poles, the equator and field extremes
  task automatic send_directed();
    logic [15:0] turns [17] = '{
      16'h0000, 16'hFFFF, 16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h2000,
      16'h1FFF, 16'h6000, 16'hA000, 16'hE000, 16'h5555, 16'hAAAA, 16'h0001,
      16'hFFFE, 16'h3000, 16'h9000
    };
    logic [15:0] cosines [17] = '{
      16'h0000, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000, 16'h0000, 16'h0064,
      16'hFF9C, 16'h4000, 16'hC000, 16'h7FFF, 16'hFFFF, 16'h0001, 16'h8001,
      16'h5A82, 16'hA57E, 16'h0000
    };
    int i;
    for (i = 0; i < 17; i++) send_item(turns[i], cosines[i]);
  endtask

  // random draws, biased a little toward poles, equator and quadrant edges
  task automatic send_random(input int count);
    logic [15:0] turn, pcos;
    int i;
    for (i = 0; i < count; i++) begin
      turn = 16'($urandom);
      if ($urandom_range(0, 7) == 0)
        turn = 16'(($urandom_range(0, 7) << 13) + $urandom_range(0, 2) - 1);
      case ($urandom_range(0, 9))
        0: pcos = 16'(16'h8000 + $urandom_range(0, 3));
        1: pcos = 16'(16'h7FFF - $urandom_range(0, 3));
        2: pcos = 16'($urandom_range(0, 4) - 2);
        default: pcos = 16'($urandom);
      endcase
      send_item(turn, pcos);
    end
  endtask

  // main sequence
  initial begin
    sb = new();
    rst_n         <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_data      <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // length after reset
    send_directed();
    send_random(180);

    // full scale length, with a long output hold-off
    program_length(15'h7FFF);
    send_directed();
    send_random(40);
    hold_req = 1'b1;
    send_random(160);

    // zero length
    program_length(15'h0000);
    send_random(120);

    // smallest nonzero length, with a full pause mid-stream
    program_length(15'h0001);
    send_random(60);
    wait_drained();
    send_random(60);

    // arbitrary length
    program_length(15'($urandom_range(2, 32766)));
    send_directed();
    send_random(200);

    program_length(15'h4000);
    send_random(150);

    // closing stretch at full rate on both sides
    calm = 1'b1;
    program_length(LEN_RESET);
    send_random(200);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

>>> sphere_point_from_uniforms.f
rtl/core/sph_pkg.sv
rtl/core/sph_front.sv
rtl/core/sph_cell.sv
rtl/core/sph_scale.sv
rtl/core/sphere_point_from_uniforms.sv
sim/sphere_point_from_uniforms_test.sv
